/* rtl/assert_macros.svh */
// assertion macros for the rtl files, included by windowed_sound_energy
// needs nothing but a clock and an active-low reset at the place of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge, so b holds at the same edge
`define ASSERT_SAME(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// a holds at an edge, so b holds at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`endif

/* rtl/wse_pkg.sv */
// shared constants and types of the windowed sound energy block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wse_pkg;

	localparam int SAMPLE_W = 12;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 12'h7FC;
	// the mask keeps bits 10 down to 2
	localparam int MAG_LSB = 2;
	localparam int MAG_MSB = 10;
	localparam int MAG_W = MAG_MSB - MAG_LSB + 1;
	localparam int SQUARE_W = 2 * MAG_W + 2 * MAG_LSB;
	localparam int LEVEL_W = 27;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
	localparam int WINDOW_LEN_DEF = 32;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 32;

	typedef struct packed {
		logic                vld;
		logic [SQUARE_W-1:0] square;
	} sq_stage_t;

endpackage

`default_nettype wire

/* rtl/wse_square.sv */
// input register and squaring stage of the windowed sound energy block
// depends on wse_pkg
`timescale 1ns / 1ps
`default_nettype none

module wse_square (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          take,
	input  wire logic [wse_pkg::SAMPLE_W-1:0]  raw_sample,
	output wse_pkg::sq_stage_t                 sq
);

	logic                       vld_s1;
	logic [wse_pkg::MAG_W-1:0]  mag_s1;
	logic                       vld_s2;
	logic [wse_pkg::SQUARE_W-1:0] square_s2;
	logic [wse_pkg::SAMPLE_W-1:0] masked;
	logic [2*wse_pkg::MAG_W-1:0]  mag_sq;

	assign masked = raw_sample & wse_pkg::SAMPLE_MASK;
	assign mag_sq = {{wse_pkg::MAG_W{1'b0}}, mag_s1} * {{wse_pkg::MAG_W{1'b0}}, mag_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= masked[wse_pkg::MAG_MSB:wse_pkg::MAG_LSB];
			// the two dropped low bits come back as four zero bits of the square
			square_s2 <= {mag_sq, {(2*wse_pkg::MAG_LSB){1'b0}}};
		end
	end

	assign sq.vld = vld_s2;
	assign sq.square = square_s2;

endmodule

`default_nettype wire

/* rtl/wse_window.sv */
// square ring, running total, change flag and result register
// depends on wse_pkg
`timescale 1ns / 1ps
`default_nettype none

module wse_window #(
	parameter int WINDOW_LEN = wse_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire wse_pkg::sq_stage_t           sq,
	output logic                              out_vld,
	output logic [wse_pkg::LEVEL_W-1:0]       energy_level,
	output logic                              level_changed
);

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int TOT_W = wse_pkg::SQUARE_W + $clog2(WINDOW_LEN);
	localparam int CMP_W = (TOT_W > wse_pkg::LEVEL_W) ? TOT_W : wse_pkg::LEVEL_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

	logic [wse_pkg::SQUARE_W-1:0] ring [WINDOW_LEN];
	logic [wse_pkg::SQUARE_W-1:0] rd_q;
	logic [SLOT_W-1:0]            slot_q;
	logic                         full_q;
	logic [TOT_W-1:0]             total_q;
	logic [wse_pkg::LEVEL_W-1:0]  kept_q;
	logic                         out_vld_q;
	logic [wse_pkg::LEVEL_W-1:0]  out_level_q;
	logic                         out_changed_q;

	logic                         commit;
	logic [SLOT_W-1:0]            nxt_slot;
	logic [wse_pkg::SQUARE_W-1:0] oldest;
	logic [TOT_W-1:0]             total_new;
	logic [wse_pkg::LEVEL_W-1:0]  level;

	assign commit = en && sq.vld;
	assign nxt_slot = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
	// entries are written in slot order, so before the first wrap the fill flag makes every oldest word count as zero
	assign oldest = full_q ? rd_q : '0;
	assign total_new = total_q - TOT_W'(oldest) + TOT_W'(sq.square);
	assign level = (CMP_W'(total_new) > CMP_W'(wse_pkg::LEVEL_MAX)) ?
		wse_pkg::LEVEL_MAX : wse_pkg::LEVEL_W'(total_new);

	// ring written at the current slot, read one slot ahead for the next word
	always_ff @(posedge clk) begin
		if (commit) begin
			ring[slot_q] <= sq.square;
			rd_q <= ring[nxt_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			full_q <= 1'b0;
			total_q <= '0;
			kept_q <= '0;
			out_vld_q <= 1'b0;
			out_changed_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sq.vld;
			if (sq.vld) begin
				slot_q <= nxt_slot;
				if (slot_q == LAST_SLOT) begin
					full_q <= 1'b1;
				end
				total_q <= total_new;
				out_changed_q <= (level != kept_q);
				kept_q <= level;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_level_q <= level;
		end
	end

	assign out_vld = out_vld_q;
	assign energy_level = out_level_q;
	assign level_changed = out_changed_q;

endmodule

`default_nettype wire

/* rtl/windowed_sound_energy.sv */
// Windowed sound energy: each word carries one raw 12-bit converter sample, masked with
// 0x7FC and squared; the result is the sum of the last WINDOW_LEN squares (saturated
// at 2^27 - 1) and a flag that is set when that level differs from the last kept level.
// One word is taken every cycle unless the result side stalls; its result reaches the
// master side through the input register, squaring stage and running-total and result
// register. The running total feeds back through its own register, and the square ring
// is a memory read one slot ahead of its write. Reset needs no clearing pass: a fill flag
// makes slots read as zero until the ring has wrapped once. A stall on the result side
// stops the whole pipeline, and the slave side is ready whenever the result register is
// free or taken.
// Depends on wse_pkg, wse_square, wse_window and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module windowed_sound_energy #(
	parameter int WINDOW_LEN = wse_pkg::WINDOW_LEN_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [11:0] raw_sample, [15:12] zero
	input  wire logic [wse_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [26:0] energy_level, [27] level_changed, [31:28] zero
	output logic [wse_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

	logic                        en;
	wse_pkg::sq_stage_t          sq;
	logic                        out_vld;
	logic [wse_pkg::LEVEL_W-1:0] energy_level;
	logic                        level_changed;

	// the whole pipeline moves unless a finished word waits on the master side
	assign en = !out_vld || m_axis_tready;
	assign s_axis_tready = en;

	wse_square u_square (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.take       (s_axis_tvalid),
		.raw_sample (s_axis_tdata[wse_pkg::SAMPLE_W-1:0]),
		.sq         (sq)
	);

	wse_window #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.sq            (sq),
		.out_vld       (out_vld),
		.energy_level  (energy_level),
		.level_changed (level_changed)
	);

	assign m_axis_tvalid = out_vld;
	assign m_axis_tdata = {{(wse_pkg::OUT_TDATA_W - wse_pkg::LEVEL_W - 1){1'b0}},
		level_changed, energy_level};

	`ASSERT_SAME(a_stall_only_when_full, clk, arst_n, !s_axis_tready, m_axis_tvalid, "slave side stalled with an empty result register")
	`ASSERT_NEXT(a_square_held_on_stall, clk, arst_n, sq.vld && !s_axis_tready, sq.vld && $stable(sq.square), "squaring stage lost its word during a stall")
	`ASSERT_NEXT(a_result_follows_square, clk, arst_n, sq.vld && s_axis_tready, m_axis_tvalid, "squared word did not reach the result register")

endmodule

`default_nettype wire
